@@ rtl/ezr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_pkg
// Shared types, constants and tables of the Euler z-y-x rotation unit.
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam int ANGLE_WIDTH     = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CORDIC_FRAC     = 30;
  localparam int CORDIC_W        = 34;
  localparam int MUL_STEPS       = 14;
  localparam logic [CORDIC_W-1:0] CORDIC_GAIN = 34'd652032874;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROLL  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PITCH = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_YAW   = 2'd2;

  // One configuration write as seen by the coefficient builder.
  typedef struct packed {
    logic                       valid;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [ANGLE_WIDTH-1:0]     data;
  } cfg_wr_t;

  // Status of the coefficient builder.
  typedef struct packed {
    logic busy;
    logic stale;
  } build_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CSTART,
    B_CWAIT,
    B_MUL,
    B_DRAIN,
    B_LOAD
  } build_state_t;

  // Operand sources of the shared coefficient multiplier.
  typedef enum logic [2:0] {
    OP_SF, OP_CF, OP_ST, OP_CT, OP_SP, OP_CP, OP_SFST, OP_CFST
  } op_src_t;

  // Arctangent of 2^-i in units of one turn, 32 fraction bits.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // First operand of each multiplier step of the matrix build.
  function automatic op_src_t mul_op_a(input logic [3:0] k);
    op_src_t r;
    case (k)
      4'd0:  r = OP_SF;
      4'd1:  r = OP_CF;
      4'd2:  r = OP_CT;
      4'd3:  r = OP_CT;
      4'd4:  r = OP_SFST;
      4'd5:  r = OP_CF;
      4'd6:  r = OP_SFST;
      4'd7:  r = OP_CF;
      4'd8:  r = OP_SF;
      4'd9:  r = OP_CFST;
      4'd10: r = OP_SF;
      4'd11: r = OP_CFST;
      4'd12: r = OP_SF;
      default: r = OP_CF;
    endcase
    return r;
  endfunction

  // Second operand of each multiplier step of the matrix build.
  function automatic op_src_t mul_op_b(input logic [3:0] k);
    op_src_t r;
    case (k)
      4'd0:  r = OP_ST;
      4'd1:  r = OP_ST;
      4'd2:  r = OP_CP;
      4'd3:  r = OP_SP;
      4'd4:  r = OP_CP;
      4'd5:  r = OP_SP;
      4'd6:  r = OP_SP;
      4'd7:  r = OP_CP;
      4'd8:  r = OP_CT;
      4'd9:  r = OP_CP;
      4'd10: r = OP_SP;
      4'd11: r = OP_SP;
      4'd12: r = OP_CP;
      default: r = OP_CT;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ezr_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, giving the
// sine and cosine of a 16-bit angle rounded to Q1.COEF_FRAC_BITS.
// ----------------------------------------------------------------------------
module ezr_cordic #(
  parameter int COEF_FRAC_BITS = 16,
  parameter int CORDIC_STEPS   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [ezr_pkg::ANGLE_WIDTH-1:0]      angle,
  output logic                                      done,
  output logic signed [COEF_FRAC_BITS+1:0]          sin_out,
  output logic signed [COEF_FRAC_BITS+1:0]          cos_out
);

  localparam int CW   = COEF_FRAC_BITS + 2;
  localparam int XW   = ezr_pkg::CORDIC_W;
  localparam int CNTW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int SH   = ezr_pkg::CORDIC_FRAC - COEF_FRAC_BITS;
  localparam logic signed [XW-1:0] HALF = XW'((64'd1 << SH) >> 1);
  localparam logic [CNTW-1:0] LAST = CNTW'(CORDIC_STEPS - 1);

  logic signed [XW-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [CNTW-1:0]      cnt_r;
  logic                 run_r, done_r, flip_r;
  logic                 flip;
  logic signed [XW-1:0] atan_v, xs, ys, xf, yf;

  // Angles in the second or third quadrant are moved by half a turn.
  assign flip = angle[15] ^ angle[14];

  // One micro-rotation.
  always_comb begin
    atan_v = XW'(ezr_pkg::atan_turn(5'(cnt_r)));
    xs     = x_r >>> cnt_r;
    ys     = y_r >>> cnt_r;
    if (!z_r[XW-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_v;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Rotation datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= ezr_pkg::CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= {{3{angle[15] ^ flip}}, angle[14:0], 16'b0};
      flip_r <= flip;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // Undo the half-turn move and round to the coefficient format.
  always_comb begin
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    xf = (xf + HALF) >>> SH;
    yf = (yf + HALF) >>> SH;
  end

  assign cos_out = xf[CW-1:0];
  assign sin_out = yf[CW-1:0];
  assign done    = done_r;

endmodule
`default_nettype wire

@@ rtl/ezr_coef.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_coef
// Angle registers and the sequencer that rebuilds the nine direction cosine
// coefficients with the CORDIC and one shared multiplier.
// ----------------------------------------------------------------------------
module ezr_coef #(
  parameter int COEF_FRAC_BITS = 16,
  parameter int CORDIC_STEPS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ezr_pkg::cfg_wr_t                  cfg_wr,
  output ezr_pkg::build_status_t                 status,
  output logic signed [COEF_FRAC_BITS+1:0]       coef [9]
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int MW = CW + 2;
  localparam logic signed [2*MW-1:0] HALF = (2*MW)'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [CW:0] CMAX = (CW+1)'((64'd1 << (CW - 1)) - 1);
  localparam logic signed [CW:0] CMIN = -(CW+1)'(64'd1 << (CW - 1));

  ezr_pkg::build_state_t state_r, state_nxt;
  logic [ezr_pkg::ANGLE_WIDTH-1:0] angle_r [3];
  logic                            stale_r;
  logic [1:0]                      ai_r;
  logic [3:0]                      k_r, tag_r;
  logic                            pv_r;
  logic signed [CW-1:0]            sin_r [3];
  logic signed [CW-1:0]            cos_r [3];
  logic signed [MW-1:0]            p_r [ezr_pkg::MUL_STEPS];
  logic signed [2*MW-1:0]          prod_r, prod_rnd;
  logic signed [CW-1:0]            coef_r [9];
  logic signed [MW-1:0]            op_a, op_b;
  logic                            cordic_start, mul_en, load_en, cfg_hit;
  logic                            cordic_done;
  logic signed [CW-1:0]            cordic_sin, cordic_cos;

  ezr_cordic #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cordic_start),
    .angle  (angle_r[ai_r]),
    .done   (cordic_done),
    .sin_out(cordic_sin),
    .cos_out(cordic_cos)
  );

  // Saturate a sum to the coefficient width.
  function automatic logic signed [CW-1:0] sat_coef(input logic signed [MW:0] v);
    logic signed [CW-1:0] r;
    if (v > MW'(CMAX))      r = CMAX[CW-1:0];
    else if (v < MW'(CMIN)) r = CMIN[CW-1:0];
    else                    r = v[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [MW-1:0] pick(input ezr_pkg::op_src_t s,
      input logic signed [CW-1:0] sn [3], input logic signed [CW-1:0] cs [3],
      input logic signed [MW-1:0] sfst, input logic signed [MW-1:0] cfst);
    logic signed [MW-1:0] r;
    case (s)
      ezr_pkg::OP_SF:   r = MW'(sn[0]);
      ezr_pkg::OP_CF:   r = MW'(cs[0]);
      ezr_pkg::OP_ST:   r = MW'(sn[1]);
      ezr_pkg::OP_CT:   r = MW'(cs[1]);
      ezr_pkg::OP_SP:   r = MW'(sn[2]);
      ezr_pkg::OP_CP:   r = MW'(cs[2]);
      ezr_pkg::OP_SFST: r = sfst;
      default:          r = cfst;
    endcase
    return r;
  endfunction

  // Angle registers; a write to a known register marks the matrix stale.
  always_comb begin
    cfg_hit = cfg_wr.valid && (cfg_wr.index == ezr_pkg::REG_ROLL ||
              cfg_wr.index == ezr_pkg::REG_PITCH || cfg_wr.index == ezr_pkg::REG_YAW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) angle_r[i] <= '0;
      stale_r <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          ezr_pkg::REG_ROLL:  angle_r[0] <= cfg_wr.data;
          ezr_pkg::REG_PITCH: angle_r[1] <= cfg_wr.data;
          ezr_pkg::REG_YAW:   angle_r[2] <= cfg_wr.data;
          default: ;
        endcase
      end
      if (cfg_hit)
        stale_r <= 1'b1;
      else if (state_r == ezr_pkg::B_IDLE)
        stale_r <= 1'b0;
    end
  end

  // Next state of the build sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ezr_pkg::B_IDLE:   if (stale_r) state_nxt = ezr_pkg::B_CSTART;
      ezr_pkg::B_CSTART: state_nxt = ezr_pkg::B_CWAIT;
      ezr_pkg::B_CWAIT: begin
        if (cordic_done) state_nxt = (ai_r == 2'd2) ? ezr_pkg::B_MUL : ezr_pkg::B_CSTART;
      end
      ezr_pkg::B_MUL: begin
        if (k_r == 4'(ezr_pkg::MUL_STEPS - 1)) state_nxt = ezr_pkg::B_DRAIN;
      end
      ezr_pkg::B_DRAIN:  state_nxt = ezr_pkg::B_LOAD;
      ezr_pkg::B_LOAD:   state_nxt = ezr_pkg::B_IDLE;
      default:           state_nxt = ezr_pkg::B_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cordic_start = (state_r == ezr_pkg::B_CSTART);
    mul_en       = (state_r == ezr_pkg::B_MUL);
    load_en      = (state_r == ezr_pkg::B_LOAD);
    status.busy  = (state_r != ezr_pkg::B_IDLE) || stale_r;
    status.stale = stale_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ezr_pkg::B_IDLE;
      ai_r    <= '0;
      k_r     <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= mul_en;
      if (state_r == ezr_pkg::B_IDLE) ai_r <= '0;
      else if (state_r == ezr_pkg::B_CWAIT && cordic_done) ai_r <= ai_r + 1'b1;
      if (mul_en) k_r <= k_r + 1'b1;
      else        k_r <= '0;
    end
  end

  // Capture sine and cosine of each angle.
  always_ff @(posedge clk) begin
    if (state_r == ezr_pkg::B_CWAIT && cordic_done) begin
      sin_r[ai_r] <= cordic_sin;
      cos_r[ai_r] <= cordic_cos;
    end
  end

  // Shared multiplier: product registered, then rounded into the scratch set.
  always_comb begin
    op_a     = pick(ezr_pkg::mul_op_a(k_r), sin_r, cos_r, p_r[0], p_r[1]);
    op_b     = pick(ezr_pkg::mul_op_b(k_r), sin_r, cos_r, p_r[0], p_r[1]);
    prod_rnd = (prod_r + HALF) >>> COEF_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= op_a * op_b;
      tag_r  <= k_r;
    end
    if (pv_r) p_r[tag_r] <= prod_rnd[MW-1:0];
  end

  // Coefficient registers, identity after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++)
        coef_r[i] <= (i % 4 == 0) ? CW'(64'd1 << COEF_FRAC_BITS) : '0;
    end else if (load_en) begin
      coef_r[0] <= sat_coef((MW+1)'(p_r[2]));
      coef_r[1] <= sat_coef((MW+1)'(p_r[3]));
      coef_r[2] <= sat_coef(-(MW+1)'(sin_r[1]));
      coef_r[3] <= sat_coef((MW+1)'(p_r[4]) - (MW+1)'(p_r[5]));
      coef_r[4] <= sat_coef((MW+1)'(p_r[6]) + (MW+1)'(p_r[7]));
      coef_r[5] <= sat_coef((MW+1)'(p_r[8]));
      coef_r[6] <= sat_coef((MW+1)'(p_r[9]) + (MW+1)'(p_r[10]));
      coef_r[7] <= sat_coef((MW+1)'(p_r[11]) - (MW+1)'(p_r[12]));
      coef_r[8] <= sat_coef((MW+1)'(p_r[13]));
    end
  end

  assign coef = coef_r;

endmodule
`default_nettype wire

@@ rtl/ezr_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ezr_dpath
// Five-stage matrix-vector pipeline: coefficient select, split partial
// products, product assembly, row sum with rounding, saturation.
// ----------------------------------------------------------------------------
module ezr_dpath #(
  parameter int DATA_WIDTH     = 32,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic signed [COEF_FRAC_BITS+1:0]   coef [9],
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_kind,
  input  wire logic signed [DATA_WIDTH-1:0]       in_vec [3],
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [DATA_WIDTH-1:0]            out_vec [3],
  output logic                                    out_saturated
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int DW = DATA_WIDTH;
  localparam int LW = DW / 2;
  localparam int HW = DW - LW;
  localparam int PW = CW + DW;
  localparam int SW = PW + 2;
  localparam int TW = SW - COEF_FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  logic [4:0]               v_r;
  logic                     adv;
  logic signed [CW-1:0]     c1_r [9];
  logic signed [DW-1:0]     v1_r [3];
  logic signed [CW+LW:0]    plo2_r [9];
  logic signed [CW+HW-1:0]  phi2_r [9];
  logic signed [PW-1:0]     p3_r [9];
  logic signed [TW-1:0]     s4_r [3];
  logic signed [DW-1:0]     o5_r [3];
  logic                     sat5_r;
  logic signed [SW-1:0]     rsum [3];
  logic                     fits [3];

  // The whole pipeline moves unless the output word is held.
  assign adv      = !v_r[4] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // Stage 1: pick the matrix or its transpose.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++)
          c1_r[r*3+c] <= in_kind ? coef[c*3+r] : coef[r*3+c];
        v1_r[r] <= in_vec[r];
      end
    end
  end

  // Stage 2: each product as low and high partial products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          plo2_r[r*3+c] <= c1_r[r*3+c] * $signed({1'b0, v1_r[c][LW-1:0]});
          phi2_r[r*3+c] <= c1_r[r*3+c] * $signed(v1_r[c][DW-1:LW]);
        end
      end
    end
  end

  // Stage 3: assemble the full products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++)
        p3_r[i] <= (PW'(phi2_r[i]) <<< LW) + PW'(plo2_r[i]);
    end
  end

  // Stage 4: row sums, rounded by the coefficient fraction.
  always_comb begin
    for (int r = 0; r < 3; r++)
      rsum[r] = SW'(p3_r[r*3]) + SW'(p3_r[r*3+1]) + SW'(p3_r[r*3+2]) + HALF;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++)
        s4_r[r] <= TW'(rsum[r] >>> COEF_FRAC_BITS);
    end
  end

  // Stage 5: clip each component to the data range.
  always_comb begin
    for (int r = 0; r < 3; r++)
      fits[r] = (s4_r[r][TW-1:DW-1] == '0) || (&s4_r[r][TW-1:DW-1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++)
        o5_r[r] <= fits[r] ? s4_r[r][DW-1:0] : (s4_r[r][TW-1] ? DMIN : DMAX);
      sat5_r <= !(fits[0] && fits[1] && fits[2]);
    end
  end

  assign out_valid     = v_r[4];
  assign out_vec       = o5_r;
  assign out_saturated = sat5_r;

endmodule
`default_nettype wire

@@ rtl/euler_zyx_vector_rotation_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// euler_zyx_vector_rotation_unit
// Rotates vectors by a z-y-x Euler-angle direction cosine matrix.
// ----------------------------------------------------------------------------
// A vector word is accepted every cycle unless the output is held or the
// matrix is stale or being rebuilt, and passes through a five-stage pipeline;
// a held output stalls all stages together. After a write to roll, pitch or
// yaw the unit rebuilds its nine coefficients and takes no word meanwhile:
// three CORDIC runs on the single iterative CORDIC, then fourteen steps of
// the shared coefficient multiplier, a drain state and a load state. Forward
// words use the matrix, inverse words its transpose; results are rounded,
// clipped to DATA_WIDTH bits and flagged when clipped.
module euler_zyx_vector_rotation_unit #(
  parameter int DATA_WIDTH     = 32,
  parameter int COEF_FRAC_BITS = 16,
  parameter int CORDIC_STEPS   = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [ezr_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  wire logic [ezr_pkg::ANGLE_WIDTH-1:0]         cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic                                    in_kind,
  input  wire logic signed [DATA_WIDTH-1:0]            in_x_in,
  input  wire logic signed [DATA_WIDTH-1:0]            in_y_in,
  input  wire logic signed [DATA_WIDTH-1:0]            in_z_in,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [DATA_WIDTH-1:0]                 out_x_out,
  output logic signed [DATA_WIDTH-1:0]                 out_y_out,
  output logic signed [DATA_WIDTH-1:0]                 out_z_out,
  output logic                                         out_saturated
);

  ezr_pkg::cfg_wr_t          cfg_wr;
  ezr_pkg::build_status_t    status;
  logic signed [COEF_FRAC_BITS+1:0] coef [9];
  logic signed [DATA_WIDTH-1:0]     vec_in [3];
  logic signed [DATA_WIDTH-1:0]     vec_out [3];
  logic                      dp_ready;

  // Configuration writes are always taken.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  ezr_coef #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .CORDIC_STEPS  (CORDIC_STEPS)
  ) u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_wr(cfg_wr),
    .status(status),
    .coef  (coef)
  );

  // Input words wait while the matrix is stale or being rebuilt.
  assign in_ready  = dp_ready && !status.busy;
  assign vec_in[0] = in_x_in;
  assign vec_in[1] = in_y_in;
  assign vec_in[2] = in_z_in;

  ezr_dpath #(
    .DATA_WIDTH    (DATA_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .coef         (coef),
    .in_valid     (in_valid && !status.busy),
    .in_ready     (dp_ready),
    .in_kind      (in_kind),
    .in_vec       (vec_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_vec      (vec_out),
    .out_saturated(out_saturated)
  );

  assign out_x_out = vec_out[0];
  assign out_y_out = vec_out[1];
  assign out_z_out = vec_out[2];

`ifndef NO_ASSERTIONS
  // A write to an angle register blocks input words on the next cycle.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && (cfg_index == ezr_pkg::REG_ROLL || cfg_index == ezr_pkg::REG_PITCH ||
     cfg_index == ezr_pkg::REG_YAW)) |=> !in_ready)
    else $error("input accepted right after an angle write");

  // No word enters while the coefficients are rebuilt.
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    status.busy |-> !in_ready)
    else $error("input accepted during coefficient rebuild");

  // A held result is not dropped by the pipeline.
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("held result word lost");
`endif

endmodule
`default_nettype wire

@@ test/euler_zyx_vector_rotation_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_zyx_vector_rotation_unit_test
// Self-checking bench for the z-y-x Euler rotation unit. A local model
// rebuilds the direction cosine matrix from the three angles through a bit
// exact CORDIC and predicts the words after the first angle writes. Vectors
// flow in bursts with random gaps, the result side stalls on its own
// pattern, and the angles are rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module euler_zyx_vector_rotation_unit_test;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int STEPS = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam longint OUT_MAX = 64'sd2147483647;
  localparam longint OUT_MIN = -64'sd2147483648;
  localparam longint COEF_MAX = 64'sd131071;
  localparam longint COEF_MIN = -64'sd131072;
  // Register index that maps to no angle register.
  localparam logic [ezr_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic sat;
  } rotated_t;

  typedef struct {
    logic kind;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic known;
    rotated_t res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ezr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = ezr_pkg::REG_ROLL;
  logic [ezr_pkg::ANGLE_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic signed [DW-1:0] in_x_in = '0;
  logic signed [DW-1:0] in_y_in = '0;
  logic signed [DW-1:0] in_z_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DW-1:0] out_x_out;
  logic signed [DW-1:0] out_y_out;
  logic signed [DW-1:0] out_z_out;
  logic out_saturated;

  // Model state: angles, matrix and the pending-rebuild flag.
  logic [15:0] angle_roll, angle_pitch, angle_yaw;
  longint dcm [9];
  logic dcm_stale;

  rotated_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [1:0] stall_mode = 2'd0;
  int stall_count = 0;

  // Arctangent of 2^-i in turns, 32 fraction bits.
  localparam logic [31:0] ATAN_TURNS [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

  euler_zyx_vector_rotation_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, FB);
  endfunction

  function automatic longint clip_coef(longint v);
    return v > COEF_MAX ? COEF_MAX : (v < COEF_MIN ? COEF_MIN : v);
  endfunction

  // Sine and cosine of an angle through the fixed-length CORDIC.
  task automatic cordic_sincos(input logic [15:0] a, output longint s, output longint c);
    logic [31:0] t;
    logic flip;
    longint x, y, z, nx;
    t = {a, 16'h0000};
    flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
    if (flip) t = t + 32'h80000000;
    z = longint'(signed'(t));
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = rnd_shift(x, 30 - FB);
    s = rnd_shift(y, 30 - FB);
  endtask

  task automatic rebuild_dcm();
    longint sf, cf, st, ct, sp, cp, sfst, cfst;
    cordic_sincos(angle_roll, sf, cf);
    cordic_sincos(angle_pitch, st, ct);
    cordic_sincos(angle_yaw, sp, cp);
    sfst = qmul(sf, st);
    cfst = qmul(cf, st);
    dcm[0] = clip_coef(qmul(ct, cp));
    dcm[1] = clip_coef(qmul(ct, sp));
    dcm[2] = clip_coef(-st);
    dcm[3] = clip_coef(qmul(sfst, cp) - qmul(cf, sp));
    dcm[4] = clip_coef(qmul(sfst, sp) + qmul(cf, cp));
    dcm[5] = clip_coef(qmul(sf, ct));
    dcm[6] = clip_coef(qmul(cfst, cp) + qmul(sf, sp));
    dcm[7] = clip_coef(qmul(cfst, sp) - qmul(sf, cp));
    dcm[8] = clip_coef(qmul(cf, ct));
  endtask

  // Expected rotated vector for one accepted word.
  task automatic rotate_vector(input logic kind, input logic signed [DW-1:0] x,
                               input logic signed [DW-1:0] y,
                               input logic signed [DW-1:0] z, output rotated_t r);
    longint v [3];
    longint acc;
    longint comp [3];
    if (dcm_stale) begin
      rebuild_dcm();
      dcm_stale = 1'b0;
    end
    v[0] = x;
    v[1] = y;
    v[2] = z;
    r.sat = 1'b0;
    for (int row = 0; row < 3; row++) begin
      acc = 64'sd1 <<< (FB - 1);
      for (int col = 0; col < 3; col++)
        acc += (kind ? dcm[col*3+row] : dcm[row*3+col]) * v[col];
      acc = acc >>> FB;
      if (acc > OUT_MAX) begin
        acc = OUT_MAX;
        r.sat = 1'b1;
      end else if (acc < OUT_MIN) begin
        acc = OUT_MIN;
        r.sat = 1'b1;
      end
      comp[row] = acc;
    end
    r.x = comp[0][DW-1:0];
    r.y = comp[1][DW-1:0];
    r.z = comp[2][DW-1:0];
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result side: stall pattern changes mode every so often.
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_count <= $urandom_range(20, 300);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 1) == 0);
      2'd2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Check every result word against the oldest expectation.
  always @(posedge clk) begin
    rotated_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", out_x_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_x_out !== want.x) report("x_out", out_x_out, want.x);
        if (out_y_out !== want.y) report("y_out", out_y_out, want.y);
        if (out_z_out !== want.z) report("z_out", out_z_out, want.z);
        if (out_saturated !== want.sat) report("saturated", out_saturated, want.sat);
      end
    end
  end

  // Watchdog over cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("euler_zyx_vector_rotation_unit_test NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write one configuration register; only called with nothing in flight.
  task automatic write_angle(input logic [ezr_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [15:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ezr_pkg::REG_ROLL: begin angle_roll = val; dcm_stale = 1'b1; end
      ezr_pkg::REG_PITCH: begin angle_pitch = val; dcm_stale = 1'b1; end
      ezr_pkg::REG_YAW: begin angle_yaw = val; dcm_stale = 1'b1; end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Send one vector word; bursts of random length separated by gaps.
  task automatic send_vector(input logic kind, input logic signed [DW-1:0] x,
                             input logic signed [DW-1:0] y,
                             input logic signed [DW-1:0] z, input logic known,
                             input rotated_t given);
    rotated_t r;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid = 1'b1;
    in_kind = kind;
    in_x_in = x;
    in_y_in = y;
    in_z_in = z;
    do @(posedge clk); while (!in_ready);
    rotate_vector(kind, x, y, z, r);
    pending_results.push_back(known ? given : r);
    @(negedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_component();
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sd524288;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sd8388608;
      default: return $urandom;
    endcase
  endfunction

  vec_row_t vector_table [$];

  task automatic add_row(input logic kind, input logic signed [DW-1:0] x,
                         input logic signed [DW-1:0] y,
                         input logic signed [DW-1:0] z, input logic known);
    vec_row_t row;
    row.kind = kind;
    row.x = x;
    row.y = y;
    row.z = z;
    row.known = known;
    // Identity matrix passes vectors through unchanged and never clips.
    row.res.x = x;
    row.res.y = y;
    row.res.z = z;
    row.res.sat = 1'b0;
    vector_table.push_back(row);
  endtask

  initial begin
    rotated_t none;
    logic [15:0] extreme_angles [4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000};
    none = '{x: 0, y: 0, z: 0, sat: 0};
    angle_roll = '0;
    angle_pitch = '0;
    angle_yaw = '0;
    for (int k = 0; k < 9; k++) dcm[k] = (k % 4 == 0) ? (64'sd1 <<< FB) : 0;
    dcm_stale = 1'b0;

    // Identity rows after reset carry their expected values directly.
    add_row(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 1'b1);
    add_row(1'b1, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 1'b1);
    add_row(1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
    add_row(1'b1, 32'sd65536, -32'sd65536, 32'sd1, 1'b1);
    add_row(1'b0, 32'sh55555555, 32'shAAAAAAAA, 32'sh7FFFFFFF, 1'b1);
    // Rows after the angle change are checked against the model.
    add_row(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    add_row(1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    add_row(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    add_row(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    add_row(1'b0, 32'sd65536, 32'sd0, 32'sd0, 1'b0);
    add_row(1'b1, 32'sd0, 32'sd65536, 32'sd0, 1'b0);
    add_row(1'b0, 32'sd0, 32'sd0, -32'sd65536, 1'b0);
    add_row(1'b1, -32'sd1, 32'sd1, -32'sd1, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < vector_table.size(); i++) begin
      if (i == 5) begin
        // Half turn on roll, extremes on pitch and yaw, and a write to the
        // unused index which must leave the matrix alone.
        write_angle(ezr_pkg::REG_ROLL, 16'h8000);
        write_angle(ezr_pkg::REG_PITCH, 16'h7FFF);
        write_angle(ezr_pkg::REG_YAW, 16'h8000);
        write_angle(REG_UNUSED, 16'h1234);
      end
      send_vector(vector_table[i].kind, vector_table[i].x, vector_table[i].y,
                  vector_table[i].z, vector_table[i].known, vector_table[i].res);
    end

    // Random phases: new angles each phase, extremes in the first few.
    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 4) begin
        write_angle(ezr_pkg::REG_ROLL, extreme_angles[phase]);
        write_angle(ezr_pkg::REG_PITCH, extreme_angles[3 - phase]);
        write_angle(ezr_pkg::REG_YAW, extreme_angles[(phase + 1) % 4]);
      end else begin
        if ($urandom_range(0, 3) != 0) write_angle(ezr_pkg::REG_ROLL, 16'($urandom));
        if ($urandom_range(0, 3) != 0) write_angle(ezr_pkg::REG_PITCH, 16'($urandom));
        write_angle(ezr_pkg::REG_YAW, 16'($urandom));
        if ($urandom_range(0, 2) == 0) write_angle(REG_UNUSED, 16'($urandom));
      end
      for (int n = 0; n < 136; n++) begin
        // Once, let every result drain before continuing.
        if (phase == 6 && n == 60) wait_drained();
        send_vector(1'($urandom_range(0, 1)), rand_component(), rand_component(),
                    rand_component(), 1'b0, none);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("euler_zyx_vector_rotation_unit_test OK");
    else
      $display("euler_zyx_vector_rotation_unit_test NOT OK");
    $finish;
  end

endmodule
